// File: hw/rtl/sbmq_pkg.sv
// Shared constants for the shared-buffer multi-queue block.
// Field widths, operation codes and status codes; no dependencies.
`timescale 1ns / 1ps

package sbmq_pkg;

    localparam int FUNC_W   = 1;
    localparam int QIDX_W   = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_ENQ = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// File: hw/rtl/shared_buffer_multi_queue_top.sv
// Several FIFO queues kept in one shared entry store with linked free list.
// Holds the link and payload memories and the per-queue pointers; uses sbmq_pkg.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------
//   in      | input     | i_in_valid / o_in_ready   | i_func, i_queue_index, i_data_in
//   out     | output    | o_out_valid / i_out_ready | o_data_out, o_status
//
// Each beat is accepted in S_IDLE, which reads the link and payload memories
// into registers; S_EXEC then writes at most one link entry and one payload
// entry back and loads the output register.
// Reset takes effect at once: a fill count marks entries not yet handed out,
// whose links are implied, so no clearing pass runs.
// A result held in a full output register stalls S_EXEC until taken.
`timescale 1ns / 1ps

module shared_buffer_multi_queue_top #(
    parameter int ENTRIES = 64,
    parameter int QUEUES  = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [sbmq_pkg::FUNC_W-1:0]         i_func,
    input  logic [sbmq_pkg::QIDX_W-1:0]         i_queue_index,
    input  logic signed [sbmq_pkg::DATA_W-1:0]  i_data_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [sbmq_pkg::DATA_W-1:0]  o_data_out,
    output logic [sbmq_pkg::STATUS_W-1:0]       o_status
);
    import sbmq_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int QD = (QUEUES < (1 << QIDX_W)) ? QUEUES : (1 << QIDX_W);
    localparam int QW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QN = 1 << QW;
    localparam logic [QIDX_W:0] QLIM = (QIDX_W + 1)'(QD);
    localparam logic [AW:0]     ENT_LIM = (AW + 1)'(ENTRIES);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic          vld;
        logic [AW-1:0] ptr;
    } t_link;

    // Memories
    t_link                    r_link_mem [ENTRIES];
    logic [DATA_W-1:0]        r_pay_mem  [ENTRIES];
    t_link                    r_link_rd;
    logic [DATA_W-1:0]        r_pay_rd;

    // Queue pointers
    logic [AW-1:0]            r_head [QN];
    logic [AW-1:0]            r_tail [QN];
    logic [QN-1:0]            r_head_vld;

    // Free list
    logic [AW-1:0]            r_free_head;
    logic                     r_free_vld;
    logic [AW:0]              r_fill;

    // Captured beat
    t_state                   r_state;
    logic [FUNC_W-1:0]        r_func;
    logic [QW-1:0]            r_q;
    logic [DATA_W-1:0]        r_data;
    logic [AW-1:0]            r_idx;
    logic [AW-1:0]            r_tail_q;
    logic                     r_hvld;
    logic                     r_last;
    logic                     r_err;

    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_data_out;
    logic [STATUS_W-1:0]      r_status;

    logic                     in_acc;
    logic [QW-1:0]            q_sel;
    logic                     q_ok;
    logic [AW-1:0]            rd_addr;
    logic                     go;
    logic                     is_enq;
    logic                     untouched;
    logic [AW:0]              next_seq;
    logic                     link_we;
    logic [AW-1:0]            link_waddr;
    t_link                    link_wdata;
    logic                     pay_we;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign q_sel       = i_queue_index[QW-1:0];
    assign q_ok        = {1'b0, i_queue_index} < QLIM;
    assign rd_addr     = (i_func == FUNC_ENQ) ? r_free_head : r_head[q_sel];

    assign go          = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign is_enq      = (r_func == FUNC_ENQ);
    // Entries at or above the fill count were never handed out: link is idx+1
    assign untouched   = {1'b0, r_idx} >= r_fill;
    assign next_seq    = {1'b0, r_idx} + 1'b1;

    assign link_we     = go && !r_err && (!is_enq || r_hvld);
    assign link_waddr  = is_enq ? r_tail_q : r_idx;
    assign link_wdata  = is_enq ? t_link'({1'b1, r_idx}) : t_link'({r_free_vld, r_free_head});
    assign pay_we      = go && !r_err && is_enq;

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_waddr] <= link_wdata;
        end
        if (in_acc) begin
            r_link_rd <= r_link_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pay_we) begin
            r_pay_mem[r_idx] <= r_data;
        end
        if (in_acc) begin
            r_pay_rd <= r_pay_mem[rd_addr];
        end
    end

    // Capture the beat and the pointers it needs
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func   <= i_func;
            r_q      <= q_sel;
            r_data   <= i_data_in;
            r_idx    <= rd_addr;
            r_tail_q <= r_tail[q_sel];
            r_hvld   <= r_head_vld[q_sel];
            r_last   <= (r_head[q_sel] == r_tail[q_sel]);
            if (i_func == FUNC_ENQ) begin
                r_err <= !q_ok || !r_free_vld;
            end else begin
                r_err <= !q_ok || !r_head_vld[q_sel];
            end
        end
        if (go && !r_err) begin
            if (is_enq) begin
                r_tail[r_q] <= r_idx;
                if (!r_hvld) begin
                    r_head[r_q] <= r_idx;
                end
            end else if (!r_last) begin
                r_head[r_q] <= r_link_rd.ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_head_vld  <= '0;
            r_free_head <= '0;
            r_free_vld  <= 1'b1;
            r_fill      <= '0;
        end else begin
            if (r_out_valid && i_out_ready && !go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (go) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        if (r_err) begin
                            r_data_out <= '0;
                            r_status   <= is_enq ? ST_FULL : ST_EMPTY;
                        end else if (is_enq) begin
                            r_data_out <= '0;
                            r_status   <= ST_OK;
                            // pop the free list
                            if (untouched) begin
                                r_free_head <= next_seq[AW-1:0];
                                r_free_vld  <= next_seq < ENT_LIM;
                                r_fill      <= r_fill + 1'b1;
                            end else begin
                                r_free_head <= r_link_rd.ptr;
                                r_free_vld  <= r_link_rd.vld;
                            end
                            r_head_vld[r_q] <= 1'b1;
                        end else begin
                            // unlink the head, push it on the free list
                            r_status        <= ST_OK;
                            r_head_vld[r_q] <= !r_last && r_link_rd.vld;
                            r_free_head     <= r_idx;
                            r_free_vld      <= 1'b1;
                            r_data_out      <= r_pay_rd;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_status    = r_status;

endmodule
